FILE: hdl/sliding_hamming_distance_unit_defines.svh
// Assertion macros used by the sliding Hamming distance unit RTL.
`ifndef SLIDING_HAMMING_DISTANCE_UNIT_DEFINES_SVH
`define SLIDING_HAMMING_DISTANCE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SHD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("shd assertion failed");
`define SHD_ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("shd assertion failed");
`else
`define SHD_ASSERT(label, prop)
`define SHD_ASSERT_ANY(label, prop)
`endif
`endif

FILE: hdl/shd_pkg.sv
// Types and constants of the sliding Hamming distance unit.
`default_nettype none
package shd_pkg;
  localparam int POS_W = 6;
  localparam int MAX_PATTERN = 1 << POS_W;
  localparam int SYM_W = 7;
  localparam int LEN_W = 7;
  localparam int SEEN_W = 31;
  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
  localparam int GROUP_W = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  typedef struct packed {
    logic shift;
    logic rotate;
    logic load;
    logic in_use;
  } cell_ctrl_t;
endpackage
`default_nettype wire

FILE: hdl/shd_if.sv
// Request and result channels of the sliding Hamming distance unit.
`default_nettype none
interface shd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [shd_pkg::POS_W-1:0] position;
  logic [shd_pkg::SYM_W-1:0] symbol;
  logic                      text_last;

  modport source (output valid, cmd, position, symbol, text_last, input ready);
  modport sink (input valid, cmd, position, symbol, text_last, output ready);
endinterface

interface shd_out_if;
  logic                       valid;
  logic                       ready;
  logic [shd_pkg::SEEN_W-1:0] alignment;
  logic [shd_pkg::LEN_W-1:0]  distance;
  logic                       final_alignment;

  modport source (output valid, alignment, distance, final_alignment, input ready);
  modport sink (input valid, alignment, distance, final_alignment, output ready);
endinterface
`default_nettype wire

FILE: hdl/shd_cell.sv
// One window cell: a text tap, its pattern symbol and the compare.
`default_nettype none
module shd_cell (
  input  wire logic                      clk,
  input  wire shd_pkg::cell_ctrl_t       ctrl,
  input  wire logic [shd_pkg::SYM_W-1:0] new_sym,
  input  wire logic [shd_pkg::SYM_W-1:0] neighbour_sym,
  input  wire logic [shd_pkg::SYM_W-1:0] neighbour_pat,
  output logic      [shd_pkg::SYM_W-1:0] tap,
  output logic      [shd_pkg::SYM_W-1:0] pattern,
  output logic                           match
);
  // text moves one cell towards the oldest end; the pattern ring turns the same way
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      tap <= neighbour_sym;
    end
    if (ctrl.rotate) begin
      pattern <= neighbour_pat;
    end else if (ctrl.load) begin
      pattern <= new_sym;
    end
  end

  assign match = ctrl.in_use && (tap == pattern);
endmodule
`default_nettype wire

FILE: hdl/shd_tally.sv
// Registered match count: popcount per group of cells, then a group sum.
`default_nettype none
module shd_tally #(
  parameter int N = 64
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [N-1:0]              match,
  output logic      [$clog2(N+1)-1:0]    total
);
  localparam int GROUPS = (N + shd_pkg::GROUP_W - 1) / shd_pkg::GROUP_W;
  localparam int GC_W = $clog2(shd_pkg::GROUP_W + 1);
  localparam int TOT_W = $clog2(N + 1);

  logic [GROUPS*shd_pkg::GROUP_W-1:0] padded;
  logic [GC_W-1:0] group_cnt [GROUPS];
  logic [GC_W-1:0] group_next [GROUPS];

  always_comb begin
    padded = '0;
    padded[N-1:0] = match;
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_next[g] = '0;
      for (int b = 0; b < shd_pkg::GROUP_W; b++) begin
        group_next[g] = group_next[g] + GC_W'(padded[g*shd_pkg::GROUP_W + b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      group_cnt <= group_next;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + TOT_W'(group_cnt[g]);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/sliding_hamming_distance_unit.sv
// Sliding Hamming distance unit: a row of window cells against a stored pattern.
// Pipeline: an accepted text request moves through the cell taps, then the tally's group
// counts, then the result registers. Throughput: one request per cycle; the
// shift/count/output pipeline stalls as a whole on result back-pressure, and a length
// write holds off requests while the pattern ring turns one cell per cycle.
// Reset: synchronous; clears the symbol count and valids, length 1; cells not reset.
`default_nettype none
`include "sliding_hamming_distance_unit_defines.svh"
module sliding_hamming_distance_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [shd_pkg::LEN_W-1:0] cfg_wdata,
  shd_in_if.sink                         item,
  shd_out_if.source                      result
);
  localparam int TOT_W = $clog2(shd_pkg::MAX_PATTERN + 1);

  logic                       adv;
  logic                       acc;
  logic                       acc_text;
  logic                       acc_load;
  logic [shd_pkg::LEN_W-1:0]  len_eff;
  logic [shd_pkg::POS_W-1:0]  pat_off;
  logic [shd_pkg::POS_W-1:0]  off_tgt;
  logic                       rot;
  logic [shd_pkg::POS_W-1:0]  load_cell;
  logic [shd_pkg::SEEN_W-1:0] seen;
  logic [shd_pkg::SEEN_W-1:0] seen_inc;

  logic                       s0_text;
  logic [shd_pkg::SEEN_W-1:0] s0_seen;
  logic                       s0_last;

  logic                       a_valid;
  logic [shd_pkg::SEEN_W-1:0] a_align;
  logic                       a_last;

  logic [shd_pkg::SYM_W-1:0]  tap [shd_pkg::MAX_PATTERN];
  logic [shd_pkg::SYM_W-1:0]  pat [shd_pkg::MAX_PATTERN];
  logic [shd_pkg::MAX_PATTERN-1:0] match;
  logic [TOT_W-1:0]           total;

  // pattern position 0 sits in cell pat_off; the newest text symbol is in the last cell
  assign off_tgt = shd_pkg::POS_W'(shd_pkg::LEN_W'(shd_pkg::MAX_PATTERN) - len_eff);
  assign rot = (pat_off != off_tgt);

  assign adv = !result.valid || result.ready;
  assign item.ready = adv && !rot;
  assign acc = item.valid && adv && !rot;
  assign acc_text = acc && (item.cmd == shd_pkg::CMD_TEXT);
  assign acc_load = acc && (item.cmd == shd_pkg::CMD_LOAD);
  assign load_cell = item.position + pat_off;
  assign seen_inc = (seen == shd_pkg::SEEN_MAX) ? seen : seen + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_eff <= shd_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        len_eff <= shd_pkg::LEN_W'(1);
      end else if (32'(cfg_wdata) > shd_pkg::MAX_PATTERN) begin
        len_eff <= shd_pkg::LEN_W'(shd_pkg::MAX_PATTERN);
      end else begin
        len_eff <= cfg_wdata;
      end
    end
  end

  // each turn of the ring moves pattern position 0 down by one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_off <= shd_pkg::POS_W'(shd_pkg::MAX_PATTERN - 1);
    end else if (rot) begin
      pat_off <= pat_off - 1'b1;
    end
  end

  // cell i holds the text symbol accepted MAX_PATTERN-1-i text requests ago
  for (genvar i = 0; i < shd_pkg::MAX_PATTERN; i++) begin : g_cell
    shd_pkg::cell_ctrl_t     ctrl;
    logic [shd_pkg::SYM_W-1:0] neighbour;

    if (i == shd_pkg::MAX_PATTERN - 1) begin : g_end
      assign neighbour = item.symbol;
    end else begin : g_mid
      assign neighbour = tap[i+1];
    end

    assign ctrl.shift  = acc_text;
    assign ctrl.rotate = rot;
    assign ctrl.load   = acc_load && (32'(load_cell) == i);
    assign ctrl.in_use = (32'(pat_off) <= i);

    shd_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_sym       (item.symbol),
      .neighbour_sym (neighbour),
      .neighbour_pat (pat[(i + 1) % shd_pkg::MAX_PATTERN]),
      .tap           (tap[i]),
      .pattern       (pat[i]),
      .match         (match[i])
    );
  end

  shd_tally #(.N(shd_pkg::MAX_PATTERN)) u_tally (
    .clk   (clk),
    .en    (adv),
    .match (match),
    .total (total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (acc_text) begin
      seen <= item.text_last ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_text <= 1'b0;
      a_valid <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      s0_text <= acc_text;
      a_valid <= s0_text && (s0_seen >= shd_pkg::SEEN_W'(len_eff));
      result.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_seen <= seen_inc;
      s0_last <= item.text_last;
      a_align <= s0_seen - shd_pkg::SEEN_W'(len_eff);
      a_last <= s0_last;
      result.alignment <= a_align;
      result.distance <= len_eff - shd_pkg::LEN_W'(total);
      result.final_alignment <= a_last;
    end
  end

  `SHD_ASSERT(a_dist_bound, result.valid |-> (result.distance <= len_eff))
  `SHD_ASSERT(a_len_range, (len_eff != '0) && (32'(len_eff) <= shd_pkg::MAX_PATTERN))
  `SHD_ASSERT(a_last_clears, (acc_text && item.text_last) |=> (seen == '0))
  `SHD_ASSERT(a_result_src, $rose(result.valid) |-> $past(a_valid))
  `SHD_ASSERT(a_ring_step, rot |=> (pat_off == $past(pat_off) - 1'b1))
endmodule
`default_nettype wire
